/* design/ohcs_pkg.sv */
// Package for the ordered hash-compaction set: sizes, payload structs,
// divider request/response structs and register indexes.
// No dependencies.
`timescale 1ns / 1ps
package ohcs_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 13;
    localparam int CB_W        = 7;
    localparam int WORD_W      = 32;
    localparam int SIG_W       = 64;
    localparam int PADDR_W     = 3;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_DEPTH);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4093);
    localparam logic [CB_W-1:0]   CB_RESET   = CB_W'(40);

    // Register indexes, taken from paddr[2].
    localparam logic REG_TABLE_SIZE      = 1'b0;
    localparam logic REG_COMPRESSED_BITS = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_PRESENT  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] key_home;
        logic [WORD_W-1:0] key_high;
        logic [WORD_W-1:0] key_low;
        logic              permanent;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [11:0]       slot_index;
        logic [SIZE_W-1:0] stored_total;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] remainder;
    } div_rsp_t;

    // (h + s) mod ts, valid while h < ts and s < ts.
    function automatic logic [ADDR_W-1:0] add_mod(input logic [ADDR_W-1:0] h,
                                                  input logic [ADDR_W-1:0] s,
                                                  input logic [SIZE_W-1:0] ts);
        logic [ADDR_W:0] sum;
        begin
            sum = {1'b0, h} + {1'b0, s};
            if (SIZE_W'(sum) >= ts) begin
                sum = sum - (ADDR_W+1)'(ts);
            end
            return sum[ADDR_W-1:0];
        end
    endfunction

endpackage

/* design/ohcs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module ohcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/ohcs_divider.sv */
// Restoring remainder unit: one dividend bit per cycle.
// Depends on ohcs_pkg.
`timescale 1ns / 1ps
module ohcs_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  ohcs_pkg::div_req_t req,
    output ohcs_pkg::div_rsp_t rsp
);
    import ohcs_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] dvd_reg, dvd_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W:0]   shifted;

    // One shift-and-subtract step per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[WORD_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, dvs_reg}) begin
                rem_next = SIZE_W'(shifted - {1'b0, dvs_reg});
            end else begin
                rem_next = SIZE_W'(shifted);
            end
            dvd_next = {dvd_reg[WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* design/ordered_hash_compaction_set_core.sv */
// Ordered hash-compaction visited-state set: a slot RAM of full bits and
// signatures, a shared remainder unit and the probing/displacing sequencer.
// Depends on ohcs_pkg, ohcs_ram and ohcs_divider.
//
// After reset the block sweeps the slot table once, one slot per cycle,
// and holds s_ready low meanwhile; configuration writes are taken
// throughout. One transaction is then handled at a time. It works out the
// home slot and then the probe step, both on the shared remainder unit,
// then does one slot RAM read and one check per probe or per hop of a
// displaced entry, works out the step of each displaced entry again on the
// remainder unit and then presents the result. The next transaction can be
// taken in the cycle after the result is presented.
// The result is held in an output register, so a waiting result does not
// stop the next transaction from being accepted.
`timescale 1ns / 1ps
module ordered_hash_compaction_set_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ohcs_pkg::in_item_t           s_payload,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ohcs_pkg::out_item_t          m_payload,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ohcs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ohcs_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b0000000001,
        S_IDLE      = 10'b0000000010,
        S_DIV_HOME  = 10'b0000000100,
        S_DIV_STEP  = 10'b0000001000,
        S_PROBE_RD  = 10'b0000010000,
        S_PROBE_CHK = 10'b0000100000,
        S_INS_RD    = 10'b0001000000,
        S_INS_CHK   = 10'b0010000000,
        S_DIV_CARRY = 10'b0100000000,
        S_EMIT      = 10'b1000000000
    } state_t;

    localparam int ENTRY_W = SIG_W + 1;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] ts_cfg_reg;
    logic [CB_W-1:0]   cb_cfg_reg;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [SIG_W-1:0]  sig_reg, sig_next;
    logic              perm_reg, perm_next;
    logic [ADDR_W-1:0] h_reg, h_next;
    logic [ADDR_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] cstep_reg, cstep_next;
    logic [SIG_W-1:0]  carried_reg, carried_next;
    logic [ADDR_W-1:0] place_reg, place_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0] stored_count_reg, stored_count_next;
    logic [SIZE_W-1:0] reduced_count_reg, reduced_count_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_slot_reg, res_slot_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_payload_reg, m_payload_next;

    logic [SIZE_W-1:0] ts_eff;
    logic [CB_W-1:0]   cb_eff;
    logic [SIG_W-1:0]  mask;
    logic [SIG_W-1:0]  t_val;
    logic              t_full;
    logic [SIZE_W-1:0] cnt_inc;
    logic [ADDR_W-1:0] new_step;
    logic              cfg_wr;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    ohcs_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    ohcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (h_reg),
        .rdata (ram_rdata)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_cfg_reg <= SIZE_RESET;
            cb_cfg_reg <= CB_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TABLE_SIZE:      ts_cfg_reg <= pwdata[SIZE_W-1:0];
                REG_COMPRESSED_BITS: cb_cfg_reg <= pwdata[CB_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TABLE_SIZE:      prdata = {{(32-SIZE_W){1'b0}}, ts_cfg_reg};
            REG_COMPRESSED_BITS: prdata = {{(32-CB_W){1'b0}}, cb_cfg_reg};
            default:             prdata = '0;
        endcase
    end

    // Clamped table size and signature mask.
    always_comb begin
        ts_eff = ts_cfg_reg;
        if (ts_cfg_reg < SIZE_MIN) begin
            ts_eff = SIZE_MIN;
        end else if (ts_cfg_reg > SIZE_MAX) begin
            ts_eff = SIZE_MAX;
        end
        cb_eff = cb_cfg_reg;
        if (cb_cfg_reg == '0) begin
            cb_eff = CB_W'(1);
        end else if (cb_cfg_reg > CB_W'(SIG_W)) begin
            cb_eff = CB_W'(SIG_W);
        end
        mask = {SIG_W{1'b1}} << (CB_W'(SIG_W) - cb_eff);
    end

    assign t_full   = ram_rdata[SIG_W];
    assign t_val    = ram_rdata[SIG_W-1:0] & mask;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign new_step = ADDR_W'(div_rsp.remainder + 1'b1);

    // Sequencer.
    always_comb begin
        state_next         = state_reg;
        clr_next           = clr_reg;
        sig_next           = sig_reg;
        perm_next          = perm_reg;
        h_next             = h_reg;
        step_next          = step_reg;
        cstep_next         = cstep_reg;
        carried_next       = carried_reg;
        place_next         = place_reg;
        cnt_next           = cnt_reg;
        stored_count_next  = stored_count_reg;
        reduced_count_next = reduced_count_reg;
        res_status_next    = res_status_reg;
        res_slot_next      = res_slot_reg;
        m_valid_next       = m_valid_reg;
        m_payload_next     = m_payload_reg;
        div_req            = '0;
        ram_we             = 1'b0;
        ram_re             = 1'b0;
        ram_waddr          = h_reg;
        ram_wdata          = {1'b1, carried_reg};
        s_ready            = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sig_next         = {s_payload.key_high, s_payload.key_low} & mask;
                    perm_next        = s_payload.permanent;
                    div_req.start    = 1'b1;
                    div_req.dividend = s_payload.key_home;
                    div_req.divisor  = ts_eff;
                    state_next       = S_DIV_HOME;
                end
            end
            S_DIV_HOME: begin
                if (div_rsp.done) begin
                    h_next           = div_rsp.remainder[ADDR_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = sig_reg[SIG_W-1:WORD_W];
                    div_req.divisor  = ts_eff - 1'b1;
                    state_next       = S_DIV_STEP;
                end
            end
            S_DIV_STEP: begin
                if (div_rsp.done) begin
                    step_next  = new_step;
                    cnt_next   = '0;
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                ram_re     = 1'b1;
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (!t_full || (t_val < sig_reg)) begin
                    // Search stopped: insert here if there is room.
                    if (stored_count_reg >= ts_eff) begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        state_next      = S_EMIT;
                    end else begin
                        place_next   = h_reg;
                        carried_next = sig_reg;
                        cstep_next   = step_reg;
                        cnt_next     = '0;
                        state_next   = S_INS_RD;
                    end
                end else if (t_val == sig_reg) begin
                    res_status_next = ST_PRESENT;
                    res_slot_next   = h_reg;
                    state_next      = S_EMIT;
                end else begin
                    h_next   = add_mod(h_reg, step_reg, ts_eff);
                    cnt_next = cnt_inc;
                    if (cnt_inc >= ts_eff) begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        state_next      = S_EMIT;
                    end else begin
                        state_next = S_PROBE_RD;
                    end
                end
            end
            S_INS_RD: begin
                ram_re     = 1'b1;
                state_next = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (!t_full) begin
                    // Empty slot takes the carried signature.
                    ram_we            = 1'b1;
                    stored_count_next = stored_count_reg + 1'b1;
                    if (perm_reg) begin
                        reduced_count_next = reduced_count_reg + 1'b1;
                    end
                    res_status_next = ST_INSERTED;
                    res_slot_next   = place_reg;
                    state_next      = S_EMIT;
                end else if (t_val < carried_reg) begin
                    // Displace the smaller resident and work out its own step.
                    ram_we           = 1'b1;
                    carried_next     = t_val;
                    div_req.start    = 1'b1;
                    div_req.dividend = t_val[SIG_W-1:WORD_W];
                    div_req.divisor  = ts_eff - 1'b1;
                    state_next       = S_DIV_CARRY;
                end else begin
                    h_next   = add_mod(h_reg, cstep_reg, ts_eff);
                    cnt_next = cnt_inc;
                    if (cnt_inc >= ts_eff) begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        state_next      = S_EMIT;
                    end else begin
                        state_next = S_INS_RD;
                    end
                end
            end
            S_DIV_CARRY: begin
                if (div_rsp.done) begin
                    cstep_next = new_step;
                    h_next     = add_mod(h_reg, new_step, ts_eff);
                    cnt_next   = SIZE_W'(1);
                    state_next = S_INS_RD;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_payload_next.status       = res_status_reg;
                    m_payload_next.slot_index   = 12'(res_slot_reg);
                    m_payload_next.stored_total = stored_count_reg;
                    state_next                  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_CLEAR;
            clr_reg           <= '0;
            stored_count_reg  <= '0;
            reduced_count_reg <= '0;
            m_valid_reg       <= 1'b0;
            cnt_reg           <= '0;
        end else begin
            state_reg         <= state_next;
            clr_reg           <= clr_next;
            stored_count_reg  <= stored_count_next;
            reduced_count_reg <= reduced_count_next;
            m_valid_reg       <= m_valid_next;
            cnt_reg           <= cnt_next;
        end
        sig_reg        <= sig_next;
        perm_reg       <= perm_next;
        h_reg          <= h_next;
        step_reg       <= step_next;
        cstep_reg      <= cstep_next;
        carried_reg    <= carried_next;
        place_reg      <= place_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_payload_reg  <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

/* design/ohcs_checker.sv */
// Port-level checks for the ordered hash-compaction set, bound to the core.
// Depends on ohcs_pkg and ordered_hash_compaction_set_core.
`timescale 1ns / 1ps
module ohcs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ohcs_pkg::out_item_t m_payload
);
    import ohcs_pkg::*;

    // The table sweep follows every reset, so no transaction is taken at once.
    a_reset_busy: assert property (@(posedge aclk) !aresetn |=> !s_ready && !m_valid)
        else $error("core ready or valid straight after reset");

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result transaction changed while stalled");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.status == ST_INSERTED || m_payload.status == ST_PRESENT
                     || m_payload.status == ST_FULL))
        else $error("undefined status code");

    // A full-table result carries slot zero.
    a_full_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status == ST_FULL |-> m_payload.slot_index == '0)
        else $error("full result with non-zero slot");

    // An accepted transaction takes the remainder unit, so ready drops next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted back to back");

endmodule

bind ordered_hash_compaction_set_core ohcs_checker u_ohcs_checker (.*);
